@@ design/boris_momentum_position_push_core_defines.svh @@
// Assertion macros for the Boris push core.
// Used by the top level only; no other dependencies.
`ifndef BORIS_MOMENTUM_POSITION_PUSH_CORE_DEFINES_SVH
`define BORIS_MOMENTUM_POSITION_PUSH_CORE_DEFINES_SVH

// check gated off while reset is high
`define BMPP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs during reset
`define BMPP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/bmpp_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Boris push core.
// No dependencies.
package bmpp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int Q_W        = 32;
   localparam int GAMMA_W    = FRAC_BITS + 1;   // 1/gamma in (0,1]
   localparam int DIV_QW     = FRAC_BITS + 2;   // quotient bits of divider
   localparam int SQRT_STEPS = 32;              // 64-bit radicand, 2 bits/step
   localparam int INVG_LAT   = 2 + SQRT_STEPS + DIV_QW;
   localparam int DIV_LAT    = DIV_QW;
   localparam int TOP_STAGES = 12;
   localparam int PIPE_LAT   = TOP_STAGES + 2 * INVG_LAT + DIV_LAT;

   localparam int REQ_W = 11 * Q_W;
   localparam int RSP_W = ((5 * Q_W + GAMMA_W + 7) / 8) * 8;

   localparam logic [63:0] ONE_Q  = 64'(1) << FRAC_BITS;
   localparam logic [63:0] ONE_Q2 = 64'(1) << (2 * FRAC_BITS);
   localparam logic [63:0] TWO_Q2 = 64'(1) << (2 * FRAC_BITS + 1);

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef enum logic [1:0] {
      CSR_E_HALF   = 2'd0,
      CSR_B_HALF   = 2'd1,
      CSR_HALF_LT  = 2'd2
   } csr_idx_type;

   typedef logic signed [Q_W-1:0] q_type;
   typedef q_type [2:0]            vec3_type;

   // values that ride alongside the arithmetic units
   typedef struct packed {
      vec3_type av;     // rotated momentum u', later u+
      vec3_type tv;     // rotation vector t
      vec3_type mom;    // u, then u-, then final u
      vec3_type bmul;   // b_half_factor * B
      vec3_type kick;   // half electric kick
      q_type    pos_y;
      q_type    pos_x;
   } carry_type;

   function automatic q_type sat32(input logic signed [65:0] v);
      if (v > SAT_HI)
         return q_type'(SAT_HI[Q_W-1:0]);
      else if (v < SAT_LO)
         return q_type'(SAT_LO[Q_W-1:0]);
      return q_type'(v[Q_W-1:0]);
   endfunction

   // Q multiply, round half up, saturate
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [63:0] prod;
      logic signed [65:0] rnd;
      prod = a * b;
      rnd  = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return sat32(rnd);
   endfunction

endpackage

@@ design/bmpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bmpp_pkg.
module bmpp_div import bmpp_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [63:0]       num,
   input  logic [63:0]       den,
   input  carry_type         car_in,
   output logic [DIV_QW-1:0] quo,
   output carry_type         car_out
);

   logic [63:0]       rem_ff [1:DIV_QW];
   logic [63:0]       den_ff [1:DIV_QW];
   logic [DIV_QW-1:0] quo_ff [1:DIV_QW];
   carry_type         car_ff [1:DIV_QW];

   logic [63:0]       rem_in [0:DIV_QW-1];
   logic [63:0]       den_in [0:DIV_QW-1];
   logic [DIV_QW-1:0] quo_in [0:DIV_QW-1];
   carry_type         car_in_s [0:DIV_QW-1];

   always_comb begin
      logic [63:0]       rem_c;
      logic [63:0]       den_c;
      logic [DIV_QW-1:0] quo_c;
      logic [63:0]       trial;
      for (int j = 0; j < DIV_QW; j++) begin
         if (j == 0) begin
            rem_c       = num;
            den_c       = den;
            quo_c       = '0;
            car_in_s[j] = car_in;
         end else begin
            rem_c       = rem_ff[j];
            den_c       = den_ff[j];
            quo_c       = quo_ff[j];
            car_in_s[j] = car_ff[j];
         end
         trial = den_c << (DIV_QW - 1 - j);
         if (rem_c >= trial) begin
            rem_c = rem_c - trial;
            quo_c[DIV_QW-1-j] = 1'b1;
         end
         rem_in[j] = rem_c;
         den_in[j] = den_c;
         quo_in[j] = quo_c;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < DIV_QW; j++) begin
            rem_ff[j+1] <= rem_in[j];
            den_ff[j+1] <= den_in[j];
            quo_ff[j+1] <= quo_in[j];
            car_ff[j+1] <= car_in_s[j];
         end
      end
   end

   assign quo     = quo_ff[DIV_QW];
   assign car_out = car_ff[DIV_QW];

endmodule

@@ design/bmpp_invg.sv @@
// Pipelined 1/gamma unit: squares, sum, bit-pair square root, divide.
// Depends on bmpp_pkg and bmpp_div.
module bmpp_invg import bmpp_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  vec3_type           vel,
   input  carry_type          car_in,
   output logic [GAMMA_W-1:0] recip_gamma,
   output carry_type          car_out
);

   logic [63:0] sq_ff [0:2];
   carry_type   sq_car_ff;
   logic [63:0] sq_in [0:2];

   logic [63:0] rt_rem_ff [0:SQRT_STEPS];
   logic [63:0] rt_res_ff [0:SQRT_STEPS];
   carry_type   rt_car_ff [0:SQRT_STEPS];
   logic [63:0] rt_rem_in [0:SQRT_STEPS-1];
   logic [63:0] rt_res_in [0:SQRT_STEPS-1];

   logic [63:0]       div_num;
   logic [DIV_QW-1:0] div_quo;

   always_comb begin
      logic [Q_W-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         mag      = vel[i][Q_W-1] ? Q_W'(-vel[i]) : Q_W'(vel[i]);
         sq_in[i] = mag * mag;
      end
   end

   always_comb begin
      logic [63:0] bitv;
      logic [63:0] tst;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         bitv = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
         tst  = rt_res_ff[k] + bitv;
         if (rt_rem_ff[k] >= tst) begin
            rt_rem_in[k] = rt_rem_ff[k] - tst;
            rt_res_in[k] = (rt_res_ff[k] >> 1) + bitv;
         end else begin
            rt_rem_in[k] = rt_rem_ff[k];
            rt_res_in[k] = rt_res_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= sq_in[i];
         sq_car_ff    <= car_in;
         rt_rem_ff[0] <= ONE_Q2 + sq_ff[0] + sq_ff[1] + sq_ff[2];
         rt_res_ff[0] <= '0;
         rt_car_ff[0] <= sq_car_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rt_rem_ff[k+1] <= rt_rem_in[k];
            rt_res_ff[k+1] <= rt_res_in[k];
            rt_car_ff[k+1] <= rt_car_ff[k];
         end
      end
   end

   // round to nearest: (2^2F + r/2) / r
   assign div_num = ONE_Q2 + (rt_res_ff[SQRT_STEPS] >> 1);

   bmpp_div u_div (
      .clock   (clock),
      .adv     (adv),
      .num     (div_num),
      .den     (rt_res_ff[SQRT_STEPS]),
      .car_in  (rt_car_ff[SQRT_STEPS]),
      .quo     (div_quo),
      .car_out (car_out)
   );

   assign recip_gamma = div_quo[GAMMA_W-1:0];

endmodule

@@ design/boris_momentum_position_push_core.sv @@
// Boris particle push core, top level.
// Depends on bmpp_pkg, bmpp_invg, bmpp_div and the defines header.
//
// Usage:
//  - req_ channel: one particle per transfer (position, momentum, E and B
//    sampled at the particle). rsp_ channel: pushed position and momentum
//    plus the new 1/gamma, one transfer per particle, in order.
//  - csr_ port: write e_half_factor, b_half_factor, half_light_step while
//    the pipe is empty. Writes take effect at the next clock edge.
//  - Throughput: one particle per cycle unless stalled. From the req
//    transfer to rsp_tvalid: two 1/gamma units of 52 stages each, an
//    18-stage divider for the rotation factor, 12 arithmetic stages.
//  - 1/gamma unit: 2 square/sum stages, 32 square root stages (two radicand
//    bits each), 18 divider stages (one quotient bit each).
//  - Stall: the whole pipe, output register included, freezes while the
//    output holds a result that rsp_tready does not take; req_tready drops
//    in that cycle. Nothing is dropped or duplicated.
//  - Reset (synchronous): clears the valid bits and sets the configuration
//    registers to zero.
module boris_momentum_position_push_core import bmpp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // pos_x, pos_y, mom_x, mom_y, mom_z, e_x, e_y, e_z, b_x, b_y, b_z
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // new_pos_x, new_pos_y, new_mom_x, new_mom_y, new_mom_z, new 1/gamma, pad
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_wen,
   input  logic [1:0]       csr_addr,
   input  logic [31:0]      csr_wdata
);

`include "boris_momentum_position_push_core_defines.svh"

   // configuration
   q_type       ehf_ff;
   q_type       bhf_ff;
   logic [30:0] hls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ehf_ff <= '0;
         bhf_ff <= '0;
         hls_ff <= '0;
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_addr))
            CSR_E_HALF:  ehf_ff <= q_type'(csr_wdata);
            CSR_B_HALF:  bhf_ff <= q_type'(csr_wdata);
            CSR_HALF_LT: hls_ff <= csr_wdata[30:0];
            default:     ;
         endcase
      end
   end

   // global advance: the pipe moves unless the output is stuck
   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff;

   assign adv        = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
   end

   logic [10:0][Q_W-1:0] req_word;
   assign req_word = req_tdata;

   // stage A: electric kick and B scaling
   carry_type a_car_ff, a_car_in;
   always_comb begin
      a_car_in       = '0;
      a_car_in.pos_x = q_type'(req_word[0]);
      a_car_in.pos_y = q_type'(req_word[1]);
      for (int i = 0; i < 3; i++) begin
         a_car_in.mom[i]  = q_type'(req_word[2+i]);
         a_car_in.kick[i] = qmul(ehf_ff, q_type'(req_word[5+i]));
         a_car_in.bmul[i] = qmul(bhf_ff, q_type'(req_word[8+i]));
      end
   end

   // stage B: u- = u + kick
   carry_type b_car_ff, b_car_in;
   always_comb begin
      b_car_in = a_car_ff;
      for (int i = 0; i < 3; i++)
         b_car_in.mom[i] = sat32(66'(a_car_ff.mom[i]) + 66'(a_car_ff.kick[i]));
   end

   logic [GAMMA_W-1:0] g1;
   carry_type          c1_car;

   bmpp_invg u_invg_pre (
      .clock       (clock),
      .adv         (adv),
      .vel         (b_car_ff.mom),
      .car_in      (b_car_ff),
      .recip_gamma (g1),
      .car_out     (c1_car)
   );

   // stage C: t = bmul * (1/gamma)
   carry_type c_car_ff, c_car_in;
   always_comb begin
      c_car_in = c1_car;
      for (int i = 0; i < 3; i++)
         c_car_in.tv[i] = qmul(c1_car.bmul[i], $signed(Q_W'(g1)));
   end

   // stage D: u- x t products and |t|^2 terms
   carry_type d_car_ff;
   vec3_type  d_pa_ff, d_pb_ff, d_sq_ff;
   vec3_type  d_pa_in, d_pb_in, d_sq_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_pa_in[i] = qmul(c_car_ff.mom[(i+1)%3], c_car_ff.tv[(i+2)%3]);
         d_pb_in[i] = qmul(c_car_ff.mom[(i+2)%3], c_car_ff.tv[(i+1)%3]);
         d_sq_in[i] = qmul(c_car_ff.tv[i], c_car_ff.tv[i]);
      end
   end

   // stage E: u' and the divisor 1 + |t|^2
   carry_type   e_car_ff, e_car_in;
   logic [63:0] e_den_ff, e_den_in;
   always_comb begin
      e_car_in = d_car_ff;
      for (int i = 0; i < 3; i++)
         e_car_in.av[i] = sat32(66'(d_car_ff.mom[i]) + 66'(d_pa_ff[i]) - 66'(d_pb_ff[i]));
      e_den_in = ONE_Q + 64'(d_sq_ff[0]) + 64'(d_sq_ff[1]) + 64'(d_sq_ff[2]);
   end

   logic [63:0]       tf_num;
   logic [DIV_QW-1:0] tf_quo;
   carry_type         c2_car;

   assign tf_num = TWO_Q2 + (e_den_ff >> 1);

   bmpp_div u_div_tf (
      .clock   (clock),
      .adv     (adv),
      .num     (tf_num),
      .den     (e_den_ff),
      .car_in  (e_car_ff),
      .quo     (tf_quo),
      .car_out (c2_car)
   );

   // stage F: s = tf * t
   carry_type f_car_ff;
   vec3_type  f_s_ff, f_s_in;
   q_type     tf_q;
   always_comb begin
      tf_q = sat32(66'(tf_quo));
      for (int i = 0; i < 3; i++)
         f_s_in[i] = qmul(tf_q, c2_car.tv[i]);
   end

   // stage G: u' x s products
   carry_type g_car_ff;
   vec3_type  g_pa_ff, g_pb_ff, g_pa_in, g_pb_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_pa_in[i] = qmul(f_car_ff.av[(i+1)%3], f_s_ff[(i+2)%3]);
         g_pb_in[i] = qmul(f_car_ff.av[(i+2)%3], f_s_ff[(i+1)%3]);
      end
   end

   // stage H: u+ = u- + u' x s (kept in av)
   carry_type h_car_ff, h_car_in;
   always_comb begin
      h_car_in = g_car_ff;
      for (int i = 0; i < 3; i++)
         h_car_in.av[i] = sat32(66'(g_car_ff.mom[i]) + 66'(g_pa_ff[i]) - 66'(g_pb_ff[i]));
   end

   // stage I: final momentum = u+ + kick
   carry_type i_car_ff, i_car_in;
   always_comb begin
      i_car_in = h_car_ff;
      for (int i = 0; i < 3; i++)
         i_car_in.mom[i] = sat32(66'(h_car_ff.av[i]) + 66'(h_car_ff.kick[i]));
   end

   logic [GAMMA_W-1:0] g2;
   carry_type          c3_car;

   bmpp_invg u_invg_post (
      .clock       (clock),
      .adv         (adv),
      .vel         (i_car_ff.mom),
      .car_in      (i_car_ff),
      .recip_gamma (g2),
      .car_out     (c3_car)
   );

   // stage J: step = half_light_step * 1/gamma
   carry_type          j_car_ff;
   logic [GAMMA_W-1:0] j_g_ff;
   q_type              j_step_ff;

   // stage K: position increments
   carry_type          k_car_ff;
   logic [GAMMA_W-1:0] k_g_ff;
   q_type              k_dx_ff, k_dy_ff;

   // stage L: output register
   q_type              rsp_px_ff, rsp_py_ff;
   vec3_type           rsp_mom_ff;
   logic [GAMMA_W-1:0] rsp_g_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_car_ff   <= a_car_in;
         b_car_ff   <= b_car_in;
         c_car_ff   <= c_car_in;
         d_car_ff   <= c_car_ff;
         d_pa_ff    <= d_pa_in;
         d_pb_ff    <= d_pb_in;
         d_sq_ff    <= d_sq_in;
         e_car_ff   <= e_car_in;
         e_den_ff   <= e_den_in;
         f_car_ff   <= c2_car;
         f_s_ff     <= f_s_in;
         g_car_ff   <= f_car_ff;
         g_pa_ff    <= g_pa_in;
         g_pb_ff    <= g_pb_in;
         h_car_ff   <= h_car_in;
         i_car_ff   <= i_car_in;
         j_car_ff   <= c3_car;
         j_g_ff     <= g2;
         j_step_ff  <= qmul($signed(Q_W'(hls_ff)), $signed(Q_W'(g2)));
         k_car_ff   <= j_car_ff;
         k_g_ff     <= j_g_ff;
         k_dx_ff    <= qmul(j_step_ff, j_car_ff.mom[0]);
         k_dy_ff    <= qmul(j_step_ff, j_car_ff.mom[1]);
         rsp_px_ff  <= sat32(66'(k_car_ff.pos_x) + 66'(k_dx_ff));
         rsp_py_ff  <= sat32(66'(k_car_ff.pos_y) + 66'(k_dy_ff));
         rsp_mom_ff <= k_car_ff.mom;
         rsp_g_ff   <= k_g_ff;
      end
   end

   assign rsp_tdata = RSP_W'({rsp_g_ff, rsp_mom_ff, rsp_py_ff, rsp_px_ff});

   // checks
   `BMPP_ASSERT(a_gamma_range, rsp_tvalid |-> (rsp_g_ff != '0) && (64'(rsp_g_ff) <= ONE_Q), "1/gamma out of (0,1]")
   `BMPP_ASSERT(a_stall_freeze, !adv |=> $stable(vld_ff), "pipe valid bits moved during a stall")
   `BMPP_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipe not empty after reset")

endmodule
